// ----- hdl/usrs_pkg.sv -----
// ----------------------------------------------------------------------------
// usrs_pkg
// Shared types and constants for the ultrasonic range sequencer.
// ----------------------------------------------------------------------------
package usrs_pkg;

  localparam int unsigned RegW       = 16;
  localparam int unsigned CfgIdxW    = 3;
  // range_cm = width * 1130 >> 16, roughly width * 0.01724
  localparam int unsigned RangeScale = 1130;
  localparam int unsigned RangeShift = 16;
  localparam logic [RegW-1:0] RangeSat  = 16'hFFFE;
  localparam logic [RegW-1:0] RangeNone = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HOLDOFF = 3'd0,
    PH_TRIGGER = 3'd1,
    PH_WAIT    = 3'd2,
    PH_MEASURE = 3'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HOLDOFF      = 3'd0,
    REG_TRIGGER      = 3'd1,
    REG_ECHO_DELAY   = 3'd2,
    REG_ECHO_TIMEOUT = 3'd3,
    REG_NEAR         = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [RegW-1:0] holdoff_us;
    logic [RegW-1:0] trigger_us;
    logic [RegW-1:0] echo_delay_us;
    logic [RegW-1:0] echo_timeout_us;
    logic [RegW-1:0] near_cm;
  } cfg_t;

  typedef struct packed {
    logic            pin_drive;
    logic            range_valid;
    logic [RegW-1:0] range_cm;
    logic            near_flag;
  } result_t;

  // a zero period behaves as one tick
  function automatic logic [RegW-1:0] at_least_one(input logic [RegW-1:0] v);
    return (v == '0) ? RegW'(1) : v;
  endfunction

endpackage

// ----- hdl/usrs_step.sv -----
// ----------------------------------------------------------------------------
// usrs_step
// One tick of the ranging sequence: next phase, timer and result.
// ----------------------------------------------------------------------------
module usrs_step #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  usrs_pkg::phase_e          phase_i,
  input  logic [TIMER_WIDTH-1:0]    timer_i,
  input  logic                      near_i,
  input  usrs_pkg::cfg_t            cfg_i,
  input  logic                      echo_i,
  output usrs_pkg::phase_e          phase_o,
  output logic [TIMER_WIDTH-1:0]    timer_o,
  output logic                      near_o,
  output usrs_pkg::result_t         result_o
);
  import usrs_pkg::*;

  // wide enough for the product and for a 16 bit slice above the shift
  localparam int unsigned PW = TIMER_WIDTH + 17;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;

  logic [TIMER_WIDTH-1:0] timer_inc;
  logic [PW-1:0]          prod;
  logic                   range_sat;
  logic [RegW-1:0]        range_meas;

  assign timer_inc  = (timer_i == TimerMax) ? timer_i : timer_i + 1'b1;
  assign prod       = PW'(timer_i) * PW'(RangeScale);
  assign range_sat  = (prod >> RangeShift) > PW'(RangeSat);
  assign range_meas = range_sat ? RangeSat : prod[RangeShift +: RegW];

  always_comb begin
    phase_o              = phase_i;
    timer_o              = timer_i;
    near_o               = near_i;
    result_o.pin_drive   = 1'b0;
    result_o.range_valid = 1'b0;
    result_o.range_cm    = '0;
    case (phase_i)
      PH_TRIGGER: begin
        result_o.pin_drive = 1'b1;
        if (timer_inc >= TIMER_WIDTH'(at_least_one(cfg_i.trigger_us))) begin
          phase_o = PH_WAIT;
          timer_o = '0;
        end else begin
          timer_o = timer_inc;
        end
      end
      PH_WAIT: begin
        if (echo_i && (timer_i >= TIMER_WIDTH'(cfg_i.echo_delay_us))) begin
          // accepting tick is the first tick of the pulse
          phase_o = PH_MEASURE;
          timer_o = TIMER_WIDTH'(1);
        end else if (timer_inc >= TIMER_WIDTH'(at_least_one(cfg_i.echo_timeout_us))) begin
          result_o.range_valid = 1'b1;
          result_o.range_cm    = RangeNone;
          phase_o              = PH_HOLDOFF;
          timer_o              = '0;
        end else begin
          timer_o = timer_inc;
        end
      end
      PH_MEASURE: begin
        if (echo_i) begin
          timer_o = timer_inc;
        end else begin
          result_o.range_valid = 1'b1;
          result_o.range_cm    = range_meas;
          near_o               = range_meas < cfg_i.near_cm;
          phase_o              = PH_HOLDOFF;
          timer_o              = '0;
        end
      end
      default: begin
        // hold-off, and any code without meaning
        phase_o = PH_HOLDOFF;
        if (timer_inc >= TIMER_WIDTH'(at_least_one(cfg_i.holdoff_us))) begin
          phase_o = PH_TRIGGER;
          timer_o = '0;
        end else begin
          timer_o = timer_inc;
        end
      end
    endcase
    result_o.near_flag = near_o;
  end

endmodule

// ----- hdl/ultrasonic_range_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_range_sequencer_core
// Single-pin ultrasonic ranger: hold-off, trigger pulse, echo wait with
// timeout, and echo pulse timing with range and near flag reporting.
// ----------------------------------------------------------------------------
//
//  channel | direction | beat contents
//  --------+-----------+--------------------------------------------------------
//  in      | sink      | echo_level (pin sample for one microsecond tick)
//  out     | source    | pin_drive_enable, pin_drive_level, range_valid,
//          |           | range_cm, near_flag
//  cfg     | sink      | register index (0..4) and 16 bit write data
//
//  one input beat per cycle is sustained while the output side is not stalled; each
//  accepted beat yields exactly one output beat through the output register
//  the rate is set by the single registered tick step (timer, phase, range
//  multiply by a constant) between the sequencer state and the output register
//  reset clears the sequencer to hold-off with the timer at zero and the
//  registers to their defaults; no clearing pass is needed
//  when the output stalls, a skid register takes one more beat, after which
//  in_ready_o drops until the output side drains
//  the cfg channel is always ready; writes are expected only while idle
//
module ultrasonic_range_sequencer_core #(
  parameter int unsigned TIMER_WIDTH = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input beat
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         echo_level_i,
  // output beat
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         pin_drive_enable_o,
  output logic                         pin_drive_level_o,
  output logic                         range_valid_o,
  output logic [usrs_pkg::RegW-1:0]    range_cm_o,
  output logic                         near_flag_o,
  // register writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [usrs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [usrs_pkg::RegW-1:0]    cfg_data_i
);
  import usrs_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // sequencer state
  phase_e                 phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic                   near_q, near_d;

  // output register and skid register
  result_t out_q, skid_q, step_res;
  logic    out_valid_q, skid_valid_q;

  logic in_accept;
  logic out_free;

  assign cfg_ready_o = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.holdoff_us      <= 16'd200;
      cfg_q.trigger_us      <= 16'd5;
      cfg_q.echo_delay_us   <= 16'd50;
      cfg_q.echo_timeout_us <= 16'd30000;
      cfg_q.near_cm         <= 16'd39;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HOLDOFF:      cfg_q.holdoff_us      <= cfg_data_i;
        REG_TRIGGER:      cfg_q.trigger_us      <= cfg_data_i;
        REG_ECHO_DELAY:   cfg_q.echo_delay_us   <= cfg_data_i;
        REG_ECHO_TIMEOUT: cfg_q.echo_timeout_us <= cfg_data_i;
        REG_NEAR:         cfg_q.near_cm         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // one tick of the sequence per accepted beat
  usrs_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .phase_i  (phase_q),
    .timer_i  (timer_q),
    .near_i   (near_q),
    .cfg_i    (cfg_q),
    .echo_i   (echo_level_i),
    .phase_o  (phase_d),
    .timer_o  (timer_d),
    .near_o   (near_d),
    .result_o (step_res)
  );

  // accept whenever the skid slot is empty
  assign in_ready_o = ~skid_valid_q;
  assign in_accept  = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HOLDOFF;
      timer_q <= '0;
      near_q  <= 1'b0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      near_q  <= near_d;
    end
  end

  // output valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // skid drains first; no beat is accepted while it is full
      out_valid_q  <= skid_valid_q | in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= step_res;
      end
    end else if (in_accept) begin
      skid_q <= step_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pin_drive_enable_o = out_q.pin_drive;
  assign pin_drive_level_o  = out_q.pin_drive;
  assign range_valid_o      = out_q.range_valid;
  assign range_cm_o         = out_q.range_cm;
  assign near_flag_o        = out_q.near_flag;

endmodule

// ----- hdl/usrs_checker.sv -----
// ----------------------------------------------------------------------------
// usrs_checker
// Port-level checks on the ranger output beats, bound to the top level.
// ----------------------------------------------------------------------------
module usrs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      pin_drive_enable_o,
  input logic                      pin_drive_level_o,
  input logic                      range_valid_o,
  input logic [usrs_pkg::RegW-1:0] range_cm_o,
  input logic                      near_flag_o
);

  // trigger drives high only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pin_drive_level_o == pin_drive_enable_o))
    else $error("pin level differs from drive enable");

  // range is zero except on a completing beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !range_valid_o) |-> (range_cm_o == '0))
    else $error("range reported without a completion");

  // a measurement never completes while the trigger is driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pin_drive_enable_o) |-> !range_valid_o)
    else $error("completion during trigger");

  // stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(range_cm_o)
                                       && $stable(range_valid_o)
                                       && $stable(pin_drive_enable_o)
                                       && $stable(near_flag_o)))
    else $error("stalled output beat changed");

endmodule

bind ultrasonic_range_sequencer_core usrs_checker u_usrs_checker (.*);
